// File: src/fm_index_backward_search_unit_defines.svh
// Assertion macros used by the checker file of the backward search unit.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef FM_INDEX_BACKWARD_SEARCH_UNIT_DEFINES_SVH
`define FM_INDEX_BACKWARD_SEARCH_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is asserted
`define FMBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define FMBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/fmbs_pkg.sv
// Package for the FM index backward search unit: sizes, codes, state type
// and the pattern byte mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmbs_pkg;

  localparam int MaxLength   = 65536;
  localparam int OccInterval = 128;
  localparam int Symbols     = 5;
  localparam int ResultLimit = 64;

  localparam int AddrW      = $clog2(MaxLength);
  localparam int OccW       = $clog2(OccInterval);
  localparam int BlkW       = AddrW - OccW;
  localparam int CkptDepth  = ((MaxLength + OccInterval - 1) / OccInterval) * Symbols;
  localparam int CkptAw     = $clog2(CkptDepth);
  localparam int CntW       = AddrW + 1;
  localparam int RangeW     = AddrW + 2;
  localparam int SymW       = 3;
  localparam int MatchW     = 7;

  // symbol codes
  localparam logic [SymW-1:0] SymA = 3'd0;
  localparam logic [SymW-1:0] SymC = 3'd1;
  localparam logic [SymW-1:0] SymG = 3'd2;
  localparam logic [SymW-1:0] SymT = 3'd3;
  localparam logic [SymW-1:0] SymN = 3'd4;

  // register index bit (byte address bit 2)
  localparam logic RegMaxMatches = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_PATTERN = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CKPT_WR,
    ST_RANK_SETUP,
    ST_RANK_SCAN,
    ST_UPDATE,
    ST_REPORT,
    ST_OUT_ADDR,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_e;

  function automatic logic [SymW-1:0] map_char(input logic [7:0] ch);
    logic [SymW-1:0] s;
    case (ch)
      8'h41, 8'h61: s = SymA;
      8'h43, 8'h63: s = SymC;
      8'h47, 8'h67: s = SymG;
      8'h54, 8'h74: s = SymT;
      default:      s = SymN;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/fmbs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fmbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/fm_index_backward_search_unit.sv
// FM index backward search unit: index load, LF-mapping search, result emit.
// Depends on fmbs_pkg and fmbs_ram.
//
//  channel | handshake               | payload
//  in      | in_valid_i, in_stall_o  | opcode bwt_code sa_position pattern_char last_symbol
//  out     | out_valid_o, out_stall_i | match_count position has_position last
//  cfg     | psel, penable, pready   | max_matches at byte address 0
//
// Clear and plain append return straight to idle; an append closing a 128-row block
// first stores all running counts. A live pattern byte runs 2 ranks: a row outside
// the index ends in setup, else its checkpoint and each BWT row from its block start
// (up to 128) are read; then the range is updated. After the range died, bytes are only
// taken in. The last byte adds a report, then address, load and a stall-waiting hold per
// item (hold only if count-only). No clearing pass; stores are read only where written.
`timescale 1ns / 1ps
`default_nettype none

module fm_index_backward_search_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [2:0]  bwt_code_i,
  input  wire logic [15:0] sa_position_i,
  input  wire logic [7:0]  pattern_char_i,
  input  wire logic        last_symbol_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      match_count_o,
  output logic [15:0]      position_o,
  output logic             has_position_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fmbs_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]          counts_q [Symbols];
  logic [CntW-1:0]          counts_d [Symbols];
  logic [CntW-1:0]          len_q, len_d;
  logic signed [RangeW-1:0] start_q, start_d, end_q, end_d;
  logic                     alive_q, alive_d;
  logic [MatchW-1:0]        maxm_q;
  logic [SymW-1:0]          sym_q, sym_d;
  logic [CntW-1:0]          cum_q, cum_d;
  logic                     plast_q, plast_d;
  logic                     ph_q, ph_d;
  logic [CntW-1:0]          rank_a_q, rank_a_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [AddrW:0]           scan_q, scan_d;
  logic                     pend_q, pend_d;
  logic                     first_q, first_d;
  logic                     blk0_q, blk0_d;
  logic [CkptAw-1:0]        ck_base_q, ck_base_d;
  logic [SymW-1:0]          ck_sel_q, ck_sel_d;
  logic [MatchW-1:0]        k_q, k_d, n_q, n_d;
  logic [CntW-1:0]          count_q, count_d;
  logic                     ovalid_q, ovalid_d;
  logic [15:0]              opos_q, opos_d;
  logic                     ohas_q, ohas_d;
  logic                     olast_q, olast_d;

  // RAM ports
  logic              wr_row;
  logic              ck_we;
  logic [CkptAw-1:0] ck_waddr, ck_raddr;
  logic [CntW-1:0]   ck_wdata, ck_rdata;
  logic [SymW-1:0]   bwt_rdata;
  logic [15:0]       sa_rdata;
  logic [AddrW-1:0]  sa_raddr;

  // rank helpers
  logic signed [RangeW-1:0] row_sel;
  logic [BlkW-1:0]          row_blk;
  logic [CkptAw-1:0]        blk_ext;
  logic                     row_bad;
  logic [CntW-1:0]          scan_base;
  logic                     rank_done;
  logic [CntW-1:0]          rank_val;

  // search and report helpers
  logic [CntW-1:0]          cum_sum;
  logic signed [RangeW-1:0] ns, ne, span;
  logic signed [RangeW-1:0] end_restart;
  logic [MatchW-1:0]        limit;
  logic [CkptAw-1:0]        app_blk;

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign match_count_o  = count_q;
  assign position_o     = opos_q;
  assign has_position_o = ohas_q;
  assign last_o         = olast_q;
  assign pready         = 1'b1;
  assign prdata = (paddr[2] == RegMaxMatches) ? {25'd0, maxm_q} : 32'd0;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxm_q <= MatchW'(ResultLimit);
    end else if (psel && penable && pwrite && (paddr[2] == RegMaxMatches)) begin
      maxm_q <= pwdata[MatchW-1:0];
    end
  end

  // stores
  assign wr_row = (state_q == ST_IDLE) && in_valid_i && (opcode_i == OP_APPEND)
                  && (len_q < CntW'(MaxLength));

  fmbs_ram #(.Width(SymW), .Depth(MaxLength)) u_bwt_ram (
    .clk_i, .we_i(wr_row), .waddr_i(len_q[AddrW-1:0]), .wdata_i(bwt_code_i),
    .raddr_i(scan_q[AddrW-1:0]), .rdata_o(bwt_rdata)
  );

  fmbs_ram #(.Width(16), .Depth(MaxLength)) u_sa_ram (
    .clk_i, .we_i(wr_row), .waddr_i(len_q[AddrW-1:0]), .wdata_i(sa_position_i),
    .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );

  fmbs_ram #(.Width(CntW), .Depth(CkptDepth)) u_ckpt_ram (
    .clk_i, .we_i(ck_we), .waddr_i(ck_waddr), .wdata_i(ck_wdata),
    .raddr_i(ck_raddr), .rdata_o(ck_rdata)
  );

  // row for the rank in progress and its checkpoint address
  assign row_sel  = ph_q ? end_q : (start_q - RangeW'(1));
  assign row_blk  = row_sel[AddrW-1:OccW];
  assign blk_ext  = CkptAw'(row_blk);
  assign ck_raddr = (blk_ext << 2) + blk_ext - CkptAw'(Symbols) + CkptAw'(sym_q);
  assign row_bad  = (row_sel < 0) || (row_sel >= $signed({1'b0, len_q}));
  assign sa_raddr = start_q[AddrW-1:0] + AddrW'(k_q);
  assign ck_waddr = ck_base_q + CkptAw'(ck_sel_q);
  assign ck_wdata = counts_q[ck_sel_q];
  assign ck_we    = (state_q == ST_CKPT_WR);
  assign app_blk  = CkptAw'(len_q[AddrW-1:OccW]);

  // cumulative count of symbols below the pattern symbol
  always_comb begin
    logic [SymW-1:0] s;
    s = map_char(pattern_char_i);
    cum_sum = '0;
    for (int i = 0; i < Symbols - 1; i++) begin
      if (SymW'(i) < s) cum_sum = cum_sum + counts_q[i];
    end
  end

  assign ns          = $signed({1'b0, cum_q}) + $signed({1'b0, rank_a_q});
  assign ne          = $signed({1'b0, cum_q}) + $signed({1'b0, cnt_q}) - RangeW'(1);
  assign span        = alive_q ? (end_q - start_q + RangeW'(1)) : RangeW'(0);
  assign end_restart = $signed({1'b0, len_q}) - RangeW'(1);
  assign limit       = (maxm_q > MatchW'(ResultLimit)) ? MatchW'(ResultLimit) : maxm_q;
  assign scan_base   = first_q ? (blk0_q ? CntW'(0) : ck_rdata) : cnt_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      for (int i = 0; i < Symbols; i++) counts_q[i] <= '0;
      len_q    <= '0;
      start_q  <= '0;
      end_q    <= -RangeW'(1);
      alive_q  <= 1'b1;
      ph_q     <= 1'b0;
      pend_q   <= 1'b0;
      first_q  <= 1'b0;
      ck_sel_q <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      counts_q <= counts_d;
      len_q    <= len_d;
      start_q  <= start_d;
      end_q    <= end_d;
      alive_q  <= alive_d;
      ph_q     <= ph_d;
      pend_q   <= pend_d;
      first_q  <= first_d;
      ck_sel_q <= ck_sel_d;
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    cum_q     <= cum_d;
    plast_q   <= plast_d;
    rank_a_q  <= rank_a_d;
    cnt_q     <= cnt_d;
    scan_q    <= scan_d;
    blk0_q    <= blk0_d;
    ck_base_q <= ck_base_d;
    n_q       <= n_d;
    count_q   <= count_d;
    opos_q    <= opos_d;
    ohas_q    <= ohas_d;
    olast_q   <= olast_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    counts_d  = counts_q;
    len_d     = len_q;
    start_d   = start_q;
    end_d     = end_q;
    alive_d   = alive_q;
    sym_d     = sym_q;
    cum_d     = cum_q;
    plast_d   = plast_q;
    ph_d      = ph_q;
    rank_a_d  = rank_a_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    first_d   = first_q;
    blk0_d    = blk0_q;
    ck_base_d = ck_base_q;
    ck_sel_d  = ck_sel_q;
    k_d       = k_q;
    n_d       = n_q;
    count_d   = count_q;
    ovalid_d  = ovalid_q;
    opos_d    = opos_q;
    ohas_d    = ohas_q;
    olast_d   = olast_q;
    rank_done = 1'b0;
    rank_val  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_CLEAR: begin
              for (int i = 0; i < Symbols; i++) counts_d[i] = '0;
              len_d   = '0;
              start_d = '0;
              end_d   = -RangeW'(1);
              alive_d = 1'b1;
            end
            OP_APPEND: begin
              start_d = '0;
              alive_d = 1'b1;
              end_d   = end_restart;
              if (wr_row) begin
                if (bwt_code_i < SymW'(Symbols)) begin
                  counts_d[bwt_code_i] = counts_q[bwt_code_i] + CntW'(1);
                end
                len_d = len_q + CntW'(1);
                end_d = $signed({1'b0, len_q});
                // row closes a block: store all running counts
                if (&len_q[OccW-1:0]) begin
                  ck_base_d = (app_blk << 2) + app_blk;
                  ck_sel_d  = '0;
                  state_d   = ST_CKPT_WR;
                end
              end
            end
            OP_PATTERN: begin
              sym_d   = map_char(pattern_char_i);
              cum_d   = cum_sum;
              plast_d = last_symbol_i;
              ph_d    = 1'b0;
              if (alive_q) state_d = ST_RANK_SETUP;
              else if (last_symbol_i) state_d = ST_REPORT;
            end
            default: ;
          endcase
        end
      end

      ST_CKPT_WR: begin
        ck_sel_d = ck_sel_q + SymW'(1);
        if (ck_sel_q == SymW'(Symbols - 1)) state_d = ST_IDLE;
      end

      ST_RANK_SETUP: begin
        if (row_bad) begin
          rank_done = 1'b1;
          rank_val  = '0;
        end else begin
          scan_d  = {1'b0, row_blk, {OccW{1'b0}}};
          blk0_d  = (row_blk == '0);
          first_d = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_RANK_SCAN;
        end
      end

      // one BWT read issued per cycle, compared in the cycle after
      ST_RANK_SCAN: begin
        first_d = 1'b0;
        cnt_d   = scan_base + CntW'(pend_q && (bwt_rdata == sym_q));
        if (scan_q <= {1'b0, row_sel[AddrW-1:0]}) begin
          pend_d = 1'b1;
          scan_d = scan_q + (AddrW+1)'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            rank_done = 1'b1;
            rank_val  = cnt_d;
          end
        end
      end

      ST_UPDATE: begin
        start_d = ns;
        end_d   = ne;
        if (ns > ne) alive_d = 1'b0;
        state_d = plast_q ? ST_REPORT : ST_IDLE;
      end

      ST_REPORT: begin
        count_d = span[CntW-1:0];
        k_d     = '0;
        if (span < $signed({1'b0, {(RangeW-MatchW-1){1'b0}}, limit})) begin
          n_d = span[MatchW-1:0];
        end else begin
          n_d = limit;
        end
        if (n_d == '0) begin
          ovalid_d = 1'b1;
          opos_d   = '0;
          ohas_d   = 1'b0;
          olast_d  = 1'b1;
          state_d  = ST_OUT_HOLD;
        end else begin
          state_d = ST_OUT_ADDR;
        end
      end

      ST_OUT_ADDR: state_d = ST_OUT_LOAD;

      ST_OUT_LOAD: begin
        ovalid_d = 1'b1;
        opos_d   = sa_rdata;
        ohas_d   = 1'b1;
        olast_d  = (k_q + MatchW'(1) == n_q);
        state_d  = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        if (!out_stall_i) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            start_d = '0;
            end_d   = end_restart;
            alive_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + MatchW'(1);
            state_d = ST_OUT_ADDR;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // first rank goes on to the second, second goes to the range update
    if (rank_done) begin
      if (!ph_q) begin
        rank_a_d = rank_val;
        ph_d     = 1'b1;
        state_d  = ST_RANK_SETUP;
      end else begin
        cnt_d   = rank_val;
        state_d = ST_UPDATE;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/fmbs_checker.sv
// Port-level checks for the FM index backward search unit, bound to the top.
// Depends on fm_index_backward_search_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fm_index_backward_search_unit_defines.svh"

module fmbs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [16:0] match_count_o,
  input wire logic [15:0] position_o,
  input wire logic        has_position_o,
  input wire logic        last_o
);

  // a pending result item blocks new input items
  `FMBS_ASSERT(a_busy_while_out, out_valid_o |-> in_stall_o, "result item shown while input open")

  // a result without a position is the only one of its pattern
  `FMBS_ASSERT(a_nopos_last, (out_valid_o && !has_position_o) |-> last_o, "empty result not last")

  // a reported position implies a nonzero count
  `FMBS_ASSERT(a_pos_count, (out_valid_o && has_position_o) |-> (match_count_o != 17'd0),
    "position with zero count")

  // stalled result item holds
  `FMBS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(position_o)),
    "stalled result item changed")

  // no result item during reset
  `FMBS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result item during reset")

endmodule

bind fm_index_backward_search_unit fmbs_checker u_fmbs_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for fm_index_backward_search_unit: loads indexes,
// runs backward searches and compares every result item with a local model.
// Depends on fmbs_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import fmbs_pkg::*;

  // result item as seen on the output channel
  typedef struct packed {
    logic [16:0] count;
    logic [15:0] pos;
    logic        has;
    logic        last;
  } match_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_CLEAR;
  logic [2:0]  bwt_code_i = '0;
  logic [15:0] sa_position_i = '0;
  logic [7:0]  pattern_char_i = '0;
  logic        last_symbol_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [16:0] match_count_o;
  logic [15:0] position_o;
  logic        has_position_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fm_index_backward_search_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // search model state
  bit [2:0]    bwt_mem [MaxLength];
  bit [15:0]   sa_mem [MaxLength];
  int unsigned occ_ckpt [CkptDepth];
  int unsigned sym_count [Symbols];
  int unsigned index_len;
  int          lo_row, hi_row;
  bit          range_live;
  int unsigned max_hits = 64;

  match_t      pending_matches[$];
  int          errors;
  int          matches_seen;
  int          patterns_done;
  bit          quiet;
  int          hold_request;
  int          hold_left;

  function automatic int unsigned char_code(logic [7:0] ch);
    case (ch)
      "A", "a": return SymA;
      "C", "c": return SymC;
      "G", "g": return SymG;
      "T", "t": return SymT;
      default:  return SymN;
    endcase
  endfunction

  // occurrences of sym in rows 0..row
  function automatic int unsigned occ_rank(int unsigned sym, int row);
    int unsigned blk, cnt;
    if (row < 0 || row >= int'(index_len)) return 0;
    blk = row / OccInterval;
    cnt = (blk > 0) ? occ_ckpt[(blk - 1) * Symbols + sym] : 0;
    for (int j = blk * OccInterval; j <= row; j++)
      if (bwt_mem[j] == sym) cnt++;
    return cnt;
  endfunction

  function automatic void reset_range();
    lo_row = 0;
    hi_row = int'(index_len) - 1;
    range_live = 1'b1;
  endfunction

  // update the model with one accepted item, queue its matches
  function automatic void search_step(logic [1:0] op, logic [2:0] code, logic [15:0] sa,
                                      logic [7:0] ch, logic lst);
    int unsigned sym, cum, total, cap, n;
    int          ns, ne;
    match_t      m;
    case (op)
      OP_CLEAR: begin
        foreach (sym_count[s]) sym_count[s] = 0;
        index_len = 0;
        reset_range();
      end
      OP_APPEND: begin
        if (index_len < MaxLength) begin
          bwt_mem[index_len] = code;
          sa_mem[index_len] = sa;
          if (code < Symbols) sym_count[code]++;
          if ((index_len + 1) % OccInterval == 0)
            for (int s = 0; s < Symbols; s++)
              occ_ckpt[(index_len / OccInterval) * Symbols + s] = sym_count[s];
          index_len++;
        end
        reset_range();
      end
      OP_PATTERN: begin
        if (range_live) begin
          sym = char_code(ch);
          cum = 0;
          for (int s = 0; s < sym; s++) cum += sym_count[s];
          ns = int'(cum + occ_rank(sym, lo_row - 1));
          ne = int'(cum + occ_rank(sym, hi_row)) - 1;
          lo_row = ns;
          hi_row = ne;
          if (ns > ne) range_live = 1'b0;
        end
        if (lst) begin
          total = range_live ? hi_row - lo_row + 1 : 0;
          cap = (max_hits > ResultLimit) ? ResultLimit : max_hits;
          n = (total < cap) ? total : cap;
          m.count = total[16:0];
          if (n == 0) begin
            m.pos = '0; m.has = 1'b0; m.last = 1'b1;
            pending_matches = {pending_matches, m};
          end else begin
            for (int k = 0; k < n; k++) begin
              m.pos = sa_mem[lo_row + k];
              m.has = 1'b1;
              m.last = (k + 1 == n);
              pending_matches = {pending_matches, m};
            end
          end
          patterns_done++;
          reset_range();
        end
      end
      default: ;
    endcase
  endfunction

  // send one item, return once it is accepted
  task automatic send_item(logic [1:0] op, logic [2:0] code, logic [15:0] sa,
                           logic [7:0] ch, logic lst);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    bwt_code_i = code;
    sa_position_i = sa;
    pattern_char_i = ch;
    last_symbol_i = lst;
    do @(posedge clk_i); while (in_stall_o);
    search_step(op, code, sa, ch, lst);
  endtask

  // pattern is given in text order; bytes go out last first
  task automatic send_pattern(byte unsigned pat[$]);
    for (int i = pat.size() - 1; i >= 0; i--)
      send_item(OP_PATTERN, 3'($urandom), 16'($urandom), pat[i], i == 0);
  endtask

  function automatic byte unsigned rand_char();
    byte unsigned alpha[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    if ($urandom_range(99) < 10) return 8'($urandom);
    return alpha[$urandom_range(7)];
  endfunction

  task automatic send_rand_pattern(int len);
    byte unsigned pat[$];
    repeat (len) pat = {pat, rand_char()};
    send_pattern(pat);
  endtask

  task automatic load_index(int rows);
    for (int i = 0; i < rows; i++)
      send_item(OP_APPEND, ($urandom_range(99) < 5) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4)),
                16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // stop sending and let every expected item and any trailing work finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // register write and read back, block idle
  task automatic set_max_hits(logic [6:0] value);
    drain();
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {RegMaxMatches, 2'b00}; pwdata = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    max_hits = value;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    @(negedge clk_i);
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== value) begin
      $display("%0t: max_matches readback expected %0d actual %0d", $time, value, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // receiver stall: random, long holds on request
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(99) < 8);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    match_t exp_m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      matches_seen++;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result count %0d position %0d", $time,
                 match_count_o, position_o);
        errors++;
      end else begin
        exp_m = pending_matches.pop_front();
        if (match_count_o !== exp_m.count) begin
          $display("%0t: match_count expected %0d actual %0d", $time, exp_m.count,
                   match_count_o);
          errors++;
        end
        if (position_o !== exp_m.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, exp_m.pos, position_o);
          errors++;
        end
        if (has_position_o !== exp_m.has) begin
          $display("%0t: has_position expected %0b actual %0b", $time, exp_m.has,
                   has_position_o);
          errors++;
        end
        if (last_o !== exp_m.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_m.last, last_o);
          errors++;
        end
      end
    end
  end

  // empty index, then directed rows covering codes, position extremes, ops
  task automatic test_directed();
    send_pattern('{"A"});
    send_pattern('{"N", "c"});
    send_item(OP_CLEAR, '0, '0, '0, 1'b0);
    send_item(OP_APPEND, SymA, 16'h0000, '0, 1'b0);
    send_item(OP_APPEND, SymC, 16'hFFFF, '0, 1'b0);
    send_item(OP_APPEND, SymG, 16'h1234, '0, 1'b0);
    send_item(OP_APPEND, SymT, 16'h8000, '0, 1'b0);
    send_item(OP_APPEND, SymN, 16'h7FFF, '0, 1'b0);
    send_item(OP_APPEND, 3'd7, 16'h0001, '0, 1'b0);
    send_item(OP_APPEND, 3'd5, 16'h0002, '0, 1'b0);
    send_item(OP_APPEND, SymA, 16'hAAAA, '0, 1'b0);
    send_pattern('{"A"});
    send_pattern('{"c"});
    send_pattern('{"g"});
    send_pattern('{"T"});
    send_pattern('{8'hFF});
    send_item(OP_RSVD, 3'd7, 16'hFFFF, 8'hFF, 1'b1);
    // append in the middle of a pattern drops it
    send_item(OP_PATTERN, '0, '0, "A", 1'b0);
    send_item(OP_APPEND, SymG, 16'h5555, '0, 1'b0);
    send_pattern('{"G"});
    // clear in the middle of a pattern
    send_item(OP_PATTERN, '0, '0, "C", 1'b0);
    send_item(OP_CLEAR, '0, '0, '0, 1'b0);
    send_pattern('{"T"});
  endtask

  // one index past the first checkpoint, searched under several limits
  task automatic test_config();
    logic [6:0] vals[4] = '{7'd0, 7'd1, 7'd127, 7'd64};
    send_item(OP_CLEAR, '0, '0, '0, 1'b0);
    quiet = 1'b1;
    load_index(130);
    quiet = 1'b0;
    foreach (vals[v]) begin
      set_max_hits(vals[v]);
      send_pattern('{"A"});
      send_pattern('{"C", "G"});
    end
  endtask

  task automatic test_random();
    for (int round = 0; round < 3; round++) begin
      if (round == 2) set_max_hits(7'($urandom_range(2, 20)));
      quiet = (round == 1);
      send_item(OP_CLEAR, '0, '0, '0, 1'b0);
      load_index($urandom_range(4, 10));
      repeat (3) begin
        if ($urandom_range(99) < 4) send_item(OP_RSVD, 3'($urandom), 16'($urandom),
                                              8'($urandom), 1'($urandom));
        send_rand_pattern($urandom_range(1, 3));
      end
    end
    quiet = 1'b0;
    set_max_hits(7'd64);
  endtask

  // long receiver hold fills the unit, then a full pause
  task automatic test_pressure();
    send_item(OP_CLEAR, '0, '0, '0, 1'b0);
    load_index(8);
    hold_request = 800;
    repeat (6) send_rand_pattern(1);
    drain();
    repeat (3) send_rand_pattern(2);
  endtask

  initial begin
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    reset_range();
    test_directed();
    test_config();
    test_random();
    test_pressure();
    drain();
    $display("Searched %0d patterns and checked %0d result items,", patterns_done,
             matches_seen);
    $display("including count-only, capped, pressure and checkpoint-crossing cases.");
    if (errors == 0) begin
      $display("** fm_index_backward_search_unit: PASSED **");
    end else begin
      $display("** fm_index_backward_search_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Timeout with %0d results still expected", pending_matches.size());
    $display("** fm_index_backward_search_unit: FAILED **");
    $finish;
  end

endmodule
